### rtl/core/fir_filter_decimator_defines.svh
// ----------------------------------------------------------------------------
// fir_filter_decimator_defines.svh
// Assertion macros used by the checker file of the FIR decimator.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_DECIMATOR_DEFINES_SVH
`define FIR_FILTER_DECIMATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FIRD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("FIR decimator check failed (same cycle)");

// Next-cycle implication, disabled while reset is high.
`define FIRD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("FIR decimator check failed (next cycle)");

`endif

### rtl/core/fird_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fird_pkg
// Types, constants and the tap table of the FIR decimator.
// ----------------------------------------------------------------------------
package fird_pkg;

  localparam int TAP_COUNT  = 21;
  localparam int PTR_W      = $clog2(TAP_COUNT);
  localparam int SEQ_W      = $clog2(TAP_COUNT + 2);
  localparam int SAMPLE_W   = 12;
  localparam int LINE_W     = 8;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = LINE_W + 1 + COEF_W;
  localparam int ACC_W      = 32;
  localparam int DAC_W      = 12;
  localparam int DEC_W      = 16;
  localparam int FACTOR_W   = 5;
  localparam int COUNT_W    = 4;

  localparam logic [PTR_W-1:0]    PTR_LAST      = PTR_W'(TAP_COUNT - 1);
  localparam logic [SEQ_W-1:0]    SEQ_ISSUE_END = SEQ_W'(TAP_COUNT);
  localparam logic [SEQ_W-1:0]    SEQ_DONE      = SEQ_W'(TAP_COUNT + 1);
  localparam logic [FACTOR_W-1:0] FACTOR_RESET  = FACTOR_W'(4);
  localparam logic [FACTOR_W-1:0] FACTOR_MAX    = FACTOR_W'(16);

  typedef enum logic [1:0] {
    FIRD_IDLE,
    FIRD_RUN,
    FIRD_HOLD
  } fird_state_t;

  // Tap k weights the sample k ticks older than the newest one.
  function automatic logic signed [COEF_W-1:0] fird_coef(input logic [PTR_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      5'd0:    c = 16'sd423;
      5'd1:    c = -16'sd1014;
      5'd2:    c = -16'sd2201;
      5'd3:    c = -16'sd3366;
      5'd4:    c = -16'sd4398;
      5'd5:    c = -16'sd5073;
      5'd6:    c = -16'sd5200;
      5'd7:    c = -16'sd4760;
      5'd8:    c = -16'sd3702;
      5'd9:    c = -16'sd2152;
      5'd10:   c = -16'sd324;
      5'd11:   c = 16'sd1655;
      5'd12:   c = 16'sd3612;
      5'd13:   c = 16'sd5351;
      5'd14:   c = 16'sd6615;
      5'd15:   c = 16'sd7180;
      5'd16:   c = 16'sd6870;
      5'd17:   c = 16'sd5584;
      5'd18:   c = 16'sd3325;
      5'd19:   c = 16'sd236;
      5'd20:   c = -16'sd3345;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/fird_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fird_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fird_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 21
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/fir_filter_decimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_decimator
// 21-tap FIR filter over an 8-bit delay line held in RAM, with a decimation
// flag on every Nth result.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         in_valid / in_stall       adc_sample
//  output    out        out_valid / out_stall     dac_code, decimated_sample,
//                                                 decimated_valid
//  config    in         cfg_wr_en                 cfg_wr_data
//
// An item goes through these steps: accept and write the delay line, read
// all 21 taps through the single RAM read port (one tap per cycle), drain the
// multiply and accumulate stages, and load the output register.
// A new request is taken while the previous result still waits downstream.
// Synchronous reset clears the 21 per-entry valid bits at once; no sweep.
// A stalled output holds the block in its final state until the output register is free.
// ----------------------------------------------------------------------------
module fir_filter_decimator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fird_pkg::SAMPLE_W-1:0]  adc_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fird_pkg::DAC_W-1:0]     dac_code,
  output logic signed [fird_pkg::DEC_W-1:0] decimated_sample,
  output logic                           decimated_valid,
  input  logic                           cfg_wr_en,
  input  logic [fird_pkg::FACTOR_W-1:0]  cfg_wr_data
);

  import fird_pkg::*;

  fird_state_t state, state_next;

  logic [PTR_W-1:0]     wpos;
  logic [PTR_W-1:0]     rd_ptr;
  logic [SEQ_W-1:0]     tap_cnt;
  logic [TAP_COUNT-1:0] line_vld;
  logic                 vbit_q;
  logic [FACTOR_W-1:0]  factor;
  logic [COUNT_W-1:0]   dec_count;
  logic                 keep_flag;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  logic [ACC_W-1:0]         acc;

  logic                 accept;
  logic                 issue;
  logic                 mul_en;
  logic                 acc_en;
  logic                 load_out;
  logic                 out_free;

  logic [LINE_W-1:0]    ram_q;
  logic [LINE_W-1:0]    tap_data;
  logic [PTR_W-1:0]     coef_idx;
  logic [FACTOR_W-1:0]  eff_factor;
  logic [FACTOR_W-1:0]  count_inc;

  fird_ram #(
    .WIDTH (LINE_W),
    .DEPTH (TAP_COUNT)
  ) u_line_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (wpos),
    .wdata (adc_sample[SAMPLE_W-1 -: LINE_W]),
    .raddr (rd_ptr),
    .rdata (ram_q)
  );

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      FIRD_IDLE: begin
        if (in_valid) state_next = FIRD_RUN;
      end
      FIRD_RUN: begin
        if (tap_cnt == SEQ_DONE) state_next = FIRD_HOLD;
      end
      FIRD_HOLD: begin
        if (out_free) state_next = FIRD_IDLE;
      end
      default: state_next = FIRD_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    mul_en   = 1'b0;
    acc_en   = 1'b0;
    load_out = 1'b0;
    unique case (state)
      FIRD_IDLE: begin
        in_stall = 1'b0;
      end
      FIRD_RUN: begin
        issue  = tap_cnt < SEQ_ISSUE_END;
        mul_en = (tap_cnt >= SEQ_W'(1)) && (tap_cnt <= SEQ_ISSUE_END);
        acc_en = (tap_cnt >= SEQ_W'(2)) && (tap_cnt <= SEQ_DONE);
      end
      FIRD_HOLD: begin
        load_out = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Entries never written since reset read as zero.
  assign tap_data  = vbit_q ? ram_q : '0;
  assign coef_idx  = PTR_W'(tap_cnt - SEQ_W'(1));
  assign prod_next = $signed({1'b0, tap_data}) * fird_coef(coef_idx);

  assign eff_factor = (factor == '0) ? FACTOR_W'(1) :
                      (factor > FACTOR_MAX) ? FACTOR_MAX : factor;
  assign count_inc  = {1'b0, dec_count} + FACTOR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FIRD_IDLE;
      wpos      <= '0;
      tap_cnt   <= '0;
      line_vld  <= '0;
      factor    <= FACTOR_RESET;
      dec_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        factor <= cfg_wr_data;
      end
      if (accept) begin
        line_vld[wpos] <= 1'b1;
        wpos           <= (wpos == PTR_LAST) ? '0 : wpos + PTR_W'(1);
        dec_count      <= (count_inc >= eff_factor) ? '0 : count_inc[COUNT_W-1:0];
        tap_cnt        <= '0;
      end else if (state == FIRD_RUN) begin
        tap_cnt <= tap_cnt + SEQ_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ptr    <= wpos;
      keep_flag <= (dec_count == '0);
      acc       <= '0;
    end else begin
      if (issue) begin
        vbit_q <= line_vld[rd_ptr];
        rd_ptr <= (rd_ptr == '0) ? PTR_LAST : rd_ptr - PTR_W'(1);
      end
      if (mul_en) begin
        prod <= prod_next;
      end
      if (acc_en) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (load_out) begin
      dac_code         <= acc[15 +: DAC_W];
      decimated_sample <= $signed(acc[4 +: DEC_W]);
      decimated_valid  <= keep_flag;
    end
  end

endmodule

### rtl/core/fird_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fird_checker
// Port-level checks of the FIR decimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "fir_filter_decimator_defines.svh"

module fird_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [fird_pkg::SAMPLE_W-1:0]  adc_sample,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [fird_pkg::DAC_W-1:0]     dac_code,
  input  logic signed [fird_pkg::DEC_W-1:0] decimated_sample,
  input  logic                           decimated_valid,
  input  logic                           cfg_wr_en,
  input  logic [fird_pkg::FACTOR_W-1:0]  cfg_wr_data
);

  import fird_pkg::*;

  logic [DAC_W+DEC_W:0] out_word;

  assign out_word = {dac_code, decimated_sample, decimated_valid};

  // A request starts the filter pass, so the input closes right after it.
  `FIRD_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // A new result only appears once a filter pass has finished.
  `FIRD_ASSERT_IMP(a_result_after_pass, clk, rst, $rose(out_valid), $past(in_stall))

  `FIRD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  `FIRD_ASSERT_NXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_word))

endmodule

bind fir_filter_decimator fird_checker u_fird_checker (.*);
